// ----- rtl/core/gkc_pkg.sv -----
// ----------------------------------------------------------------------------
// Graph coloring search package
// Shared constants, request codes and the control/status structs that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package gkc_pkg;

  localparam int unsigned NodesDef = 16;
  localparam int unsigned MaxNodes = 16;
  localparam int unsigned RowW     = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned ColorW   = 5;

  localparam logic [ColorW-1:0] NumColorsRst = 5'd3;

  // Request kinds carried on the input tuser.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic load_row;    // write one adjacency row from the input request
    logic start;       // clear trial colors, search from node 0
    logic step;        // one search step at the current node
    logic emit_start;  // rewind the node counter for reporting
    logic emit_load;   // load the output register with the current node
    logic emit_fail;   // load the output register with the no-coloring result
  } gkc_cmd_t;

  typedef struct packed {
    logic self_loop;   // some node has an edge to itself
    logic n_done;      // every node holds a color
    logic step_fail;   // node 0 ran out of colors in this step
    logic emit_last;   // current node is the last one
    logic out_free;    // output register can take a new result
  } gkc_sts_t;

endpackage

// ----- rtl/core/graph_k_coloring_search_top.sv -----
// ----------------------------------------------------------------------------
// Graph k-coloring search
// Loads adjacency rows, then searches colorings in lexicographic order with
// backtracking and reports the first valid one, one node per result.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tuser=req_type, tdata=row_index,row_bits
//  m_axis    out  tvalid/tready           tuser=found, tlast=last,
//                                         tdata=node_index,node_color
//  cfg       in   cfg_we_i                cfg_wdata_i=num_colors
//
// A row load is taken in the idle state. A search is accepted, then checked
// for self loops, then runs the backtracking loop one step per cycle, with a
// single clash check per step, then rewinds the node counter for reporting;
// then one node is reported per cycle while the output is taken. A self loop
// skips the steps and the rewind; a self loop, or node 0 running out of
// colors, reports the no-coloring result.
// Reset clears the adjacency rows and sets num_colors to 3.
// Output stalls hold the report; the next request is taken once the last
// result sits in the output register.
// ----------------------------------------------------------------------------
module graph_k_coloring_search_top #(
  parameter int unsigned NODES = gkc_pkg::NodesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [3:0] row_index, [19:4] row_bits, rest zero
  input  logic        s_axis_tuser_i,   // [0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [3:0] node_index, [8:4] node_color, rest zero
  output logic        m_axis_tuser_o,   // [0] found
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);

  gkc_pkg::gkc_cmd_t cmd;
  gkc_pkg::gkc_sts_t sts;

  logic [gkc_pkg::IdxW-1:0]   out_index;
  logic [gkc_pkg::ColorW-1:0] out_color;

  gkc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_type_i  (s_axis_tuser_i),
    .req_ready_o (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gkc_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .row_index_i (s_axis_tdata_i[3:0]),
    .row_bits_i  (s_axis_tdata_i[19:4]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_found_o (m_axis_tuser_o),
    .out_index_o (out_index),
    .out_color_o (out_color),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'b0, out_color, out_index};

endmodule

// ----- rtl/core/gkc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Graph coloring search controller
// Sequences row loads, the backtracking search and the result reporting.
// ----------------------------------------------------------------------------
module gkc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_type_i,
  output logic              req_ready_o,
  input  gkc_pkg::gkc_sts_t sts_i,
  output gkc_pkg::gkc_cmd_t cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCheck  = 3'd1;
  localparam logic [2:0] StSearch = 3'd2;
  localparam logic [2:0] StEmit   = 3'd3;
  localparam logic [2:0] StFail   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_type_i == gkc_pkg::REQ_SEARCH) begin
            cmd_o.start = 1'b1;
            state_d     = StCheck;
          end else begin
            cmd_o.load_row = 1'b1;
          end
        end
      end
      StCheck: begin
        state_d = sts_i.self_loop ? StFail : StSearch;
      end
      StSearch: begin
        if (sts_i.n_done) begin
          cmd_o.emit_start = 1'b1;
          state_d          = StEmit;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.step_fail) begin
            state_d = StFail;
          end
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = StIdle;
          end
        end
      end
      StFail: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fail = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Requests are taken only while no search or report is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step || cmd_o.emit_load) |-> !req_ready_o)
    else $error("request accepted during a search");

endmodule

// ----- rtl/core/gkc_dpath.sv -----
// ----------------------------------------------------------------------------
// Graph coloring search datapath
// Adjacency rows, trial colors, the node counter, the clash check and the
// output register.
// ----------------------------------------------------------------------------
module gkc_dpath #(
  parameter int unsigned NODES = gkc_pkg::NodesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gkc_pkg::gkc_cmd_t           cmd_i,
  output gkc_pkg::gkc_sts_t           sts_o,
  input  logic                        cfg_we_i,
  input  logic [gkc_pkg::ColorW-1:0]  cfg_wdata_i,
  input  logic [gkc_pkg::IdxW-1:0]    row_index_i,
  input  logic [gkc_pkg::RowW-1:0]    row_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_found_o,
  output logic [gkc_pkg::IdxW-1:0]    out_index_o,
  output logic [gkc_pkg::ColorW-1:0]  out_color_o,
  output logic                        out_last_o
);

  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned NW = $clog2(NODES + 1);
  localparam int unsigned CW = gkc_pkg::ColorW;

  logic [NODES-1:0] adj_q [NODES];
  logic [CW-1:0]    colors_q [NODES];
  logic [NW-1:0]    n_q;
  logic [CW-1:0]    k_q;

  logic             out_valid_q;
  logic             out_found_q;
  logic [IW-1:0]    out_index_q;
  logic [CW-1:0]    out_color_q;
  logic             out_last_q;

  logic [IW-1:0]    n_idx;
  logic [CW-1:0]    cur;
  logic [CW:0]      cand;
  logic             over;
  logic [NODES-1:0] nbr;
  logic [NODES-1:0] clash_vec;
  logic             clash;
  logic [NODES-1:0] diag;
  logic             row_ok;

  assign n_idx = n_q[IW-1:0];
  assign cur   = colors_q[n_idx];
  assign cand  = {1'b0, cur} + (CW+1)'(1);
  assign over  = cand > {1'b0, k_q};

  // An edge in either direction counts, so the row and the column are merged.
  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      nbr[j]       = adj_q[n_idx][j] | adj_q[j][n_idx];
      clash_vec[j] = nbr[j] && (NW'(j) < n_q) && ({1'b0, colors_q[j]} == cand);
      diag[j]      = adj_q[j][j];
    end
  end

  assign clash  = |clash_vec;
  assign row_ok = {1'b0, row_index_i} < (gkc_pkg::IdxW+1)'(NODES);

  assign sts_o.self_loop = |diag;
  assign sts_o.n_done    = n_q == NW'(NODES);
  assign sts_o.step_fail = over && (n_q == '0);
  assign sts_o.emit_last = n_q == NW'(NODES - 1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= gkc_pkg::NumColorsRst;
    end else if (cfg_we_i) begin
      k_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        adj_q[i] <= '0;
      end
    end else if (cmd_i.load_row && row_ok) begin
      adj_q[row_index_i[IW-1:0]] <= row_bits_i[NODES-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        colors_q[i] <= '0;
      end
      n_q <= '0;
    end else begin
      if (cmd_i.start) begin
        for (int i = 0; i < NODES; i++) begin
          colors_q[i] <= '0;
        end
        n_q <= '0;
      end else if (cmd_i.step) begin
        if (over) begin
          colors_q[n_idx] <= '0;
          if (n_q != '0) begin
            n_q <= n_q - NW'(1);
          end
        end else begin
          colors_q[n_idx] <= cand[CW-1:0];
          if (!clash) begin
            n_q <= n_q + NW'(1);
          end
        end
      end else if (cmd_i.emit_start) begin
        n_q <= '0;
      end else if (cmd_i.emit_load) begin
        n_q <= n_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.emit_fail) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_found_q <= 1'b1;
      out_index_q <= n_idx;
      out_color_q <= cur;
      out_last_q  <= sts_o.emit_last;
    end else if (cmd_i.emit_fail) begin
      out_found_q <= 1'b0;
      out_index_q <= '0;
      out_color_q <= '0;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_index_o = gkc_pkg::IdxW'(out_index_q);
  assign out_color_o = out_color_q;
  assign out_last_o  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(NODES))
    else $error("node counter beyond node count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> (cur != '0) && (cur <= k_q) && (n_q < NW'(NODES)))
    else $error("reported color out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_color_q == '0) && out_last_q)
    else $error("no-coloring result malformed");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Graph k-coloring search testbench
// Streams adjacency row loads and search requests into the block, predicts
// the first valid coloring in lexicographic order for each search, and checks
// every reported node against that prediction. Sender and receiver idle at
// random, the receiver once holds off long enough to stall the input, and the
// color count is rewritten between phases once all answers have come back.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Nodes = gkc_pkg::NodesDef;
  localparam logic [gkc_pkg::RowW-1:0] NodeMask =
    {gkc_pkg::RowW{1'b1}} >> (gkc_pkg::RowW - Nodes);
  localparam int unsigned StepBudget = 4000;
  localparam int unsigned StallLimit = 200000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned ConfigGap = 8;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned PhaseItems = 14;
  localparam logic [7:0][gkc_pkg::ColorW-1:0] PhaseColors =
    {5'd5, 5'd3, 5'd4, 5'd31, 5'd0, 5'd2, 5'd16, 5'd1};

  typedef struct packed {
    logic                     kind;
    logic [gkc_pkg::IdxW-1:0] row;
    logic [gkc_pkg::RowW-1:0] bits;
  } request_t;

  typedef struct packed {
    logic                       found;
    logic [gkc_pkg::IdxW-1:0]   node;
    logic [gkc_pkg::ColorW-1:0] color;
    logic                       last;
  } answer_t;

  typedef logic [Nodes-1:0][gkc_pkg::RowW-1:0]   adj_t;
  typedef logic [Nodes-1:0][gkc_pkg::ColorW-1:0] coloring_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       s_valid = 1'b0;
  logic                       s_ready;
  request_t                   s_req = '0;
  logic                       m_valid;
  logic                       m_ready = 1'b0;
  logic [15:0]                m_tdata;
  logic                       m_tuser;
  logic                       m_tlast;
  logic                       cfg_we = 1'b0;
  logic [gkc_pkg::ColorW-1:0] cfg_wdata = '0;

  request_t    request_q[$];
  answer_t     expected_colors[$];
  adj_t        model_rows = '0;
  adj_t        plan_rows = '0;
  logic [gkc_pkg::ColorW-1:0] model_k = gkc_pkg::NumColorsRst;
  logic [gkc_pkg::ColorW-1:0] plan_k = gkc_pkg::NumColorsRst;
  int unsigned planned = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 74;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        in_taken = 1'b0;
  int unsigned quiet = 0;

  always #10 clk = ~clk;

  graph_k_coloring_search_top #(
    .NODES(Nodes)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  ({4'b0, s_req.bits, s_req.row}),
    .s_axis_tuser_i  (s_req.kind),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  // Depth-first search over colors 1..k, node 0 most significant. Prefixes
  // with a clash are pruned, which gives the same first coloring as a full
  // sweep. The walk gives up once it exceeds the step budget.
  function automatic bit first_coloring(input adj_t rows,
                                        input logic [gkc_pkg::ColorW-1:0] k,
                                        output coloring_t cols,
                                        output int unsigned steps);
    int trial [Nodes];
    int n;
    int j;
    bit clash;
    steps = 0;
    cols = '0;
    for (n = 0; n < Nodes; n++) begin
      trial[n] = 0;
      if (rows[n][n]) return 1'b0;
    end
    n = 0;
    while (n < Nodes) begin
      if (steps > StepBudget) return 1'b0;
      steps++;
      trial[n]++;
      if (trial[n] > k) begin
        trial[n] = 0;
        if (n == 0) return 1'b0;
        n--;
      end else begin
        clash = 1'b0;
        for (j = 0; j < n; j++) begin
          if ((rows[n][j] || rows[j][n]) && trial[j] == trial[n]) clash = 1'b1;
        end
        if (!clash) n++;
      end
    end
    for (n = 0; n < Nodes; n++) cols[n] = trial[n][gkc_pkg::ColorW-1:0];
    return 1'b1;
  endfunction

  task automatic predict_request(input request_t rq);
    coloring_t   cols;
    int unsigned steps;
    int          i;
    if (rq.kind == gkc_pkg::REQ_LOAD) begin
      if (rq.row < Nodes) model_rows[rq.row] = rq.bits & NodeMask;
    end else if (!first_coloring(model_rows, model_k, cols, steps)) begin
      expected_colors.push_back('{1'b0, '0, '0, 1'b1});
    end else begin
      for (i = 0; i < Nodes; i++) begin
        expected_colors.push_back('{1'b1, gkc_pkg::IdxW'(i), cols[i], i == Nodes - 1});
      end
    end
  endtask

  task automatic queue_load(input logic [gkc_pkg::IdxW-1:0] row,
                            input logic [gkc_pkg::RowW-1:0] bits);
    request_q.push_back('{gkc_pkg::REQ_LOAD, row, bits});
    if (row < Nodes) plan_rows[row] = bits & NodeMask;
    planned++;
  endtask

  // Before a search is queued, rows are cleared until the planned graph can
  // be searched within the step budget, so no search runs for ages.
  task automatic queue_search();
    coloring_t   cols;
    int unsigned steps;
    int          r;
    void'(first_coloring(plan_rows, plan_k, cols, steps));
    while (steps > StepBudget) begin
      r = $urandom_range(Nodes - 1);
      while (plan_rows[r] == '0) r = (r + 1) % Nodes;
      queue_load(gkc_pkg::IdxW'(r), '0);
      void'(first_coloring(plan_rows, plan_k, cols, steps));
    end
    request_q.push_back('{gkc_pkg::REQ_SEARCH, gkc_pkg::IdxW'($urandom),
                          gkc_pkg::RowW'($urandom)});
    planned++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (request_q.size() != 0 || s_valid || expected_colors.size() != 0);
  endtask

  task automatic set_num_colors(input logic [gkc_pkg::ColorW-1:0] k);
    wait_drained();
    // A trailing row load produces no answer, so give it time to land.
    repeat (ConfigGap) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= k;
    model_k = k;
    plan_k = k;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic note_error(input string what, input answer_t want, input answer_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected found=%0d node=%0d color=%0d last=%0d",
               what, want.found, want.node, want.color, want.last);
      $display("  got found=%0d node=%0d color=%0d last=%0d",
               got.found, got.node, got.color, got.last);
    end
  endtask

  // Request driver: a request stays on the bus until it is taken.
  always @(negedge clk) begin
    if (!s_valid || in_taken) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_req <= request_q.pop_front();
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= s_valid && s_ready;
    if (s_valid && s_ready) predict_request(s_req);
  end

  // One long receiver hold-off, started by a search while more requests wait.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && s_valid && s_ready && s_req.kind == gkc_pkg::REQ_SEARCH &&
                 request_q.size() >= 4) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (m_valid && m_ready) begin
      got = '{m_tuser, m_tdata[3:0], m_tdata[8:4], m_tlast};
      if (expected_colors.size() == 0) begin
        note_error("Result with none expected", '0, got);
      end else begin
        want = expected_colors.pop_front();
        if (got !== want) note_error("Result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int                       p;
    int unsigned              start;
    int                       r;
    logic [gkc_pkg::RowW-1:0] bits;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset color count of three.
    queue_search();                 // empty graph: every node gets color 1
    queue_load(4'd0, 16'hFFFF);     // self loop on node 0
    queue_search();
    queue_load(4'd0, 16'hFFFE);     // star around node 0
    queue_search();
    queue_load(4'd1, 16'h0004);
    queue_load(4'd3, 16'h0006);     // edges given only from the higher node
    queue_load(4'd0, 16'h000E);     // nodes 0..3 now form a four-clique
    queue_search();
    queue_load(4'd15, 16'h8000);    // self loop on the last node
    queue_search();
    queue_load(4'd1, 16'h0000);
    queue_load(4'd15, 16'h7FFF);
    queue_search();
    queue_load(4'd15, 16'h2AAA);
    queue_load(4'd7, 16'h5555);
    queue_search();

    for (p = 0; p < 8; p++) begin
      set_num_colors(p == 7 ? gkc_pkg::ColorW'($urandom_range(1, 16)) : PhaseColors[p]);
      if (p < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 74;
      end else if (p < 6) begin
        send_idle_pct = 74;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      @(posedge clk);
      start = planned;
      while (planned - start < PhaseItems) begin
        repeat ($urandom_range(0, 4)) begin
          r = $urandom_range(Nodes - 1);
          case ($urandom_range(9))
            0: bits = gkc_pkg::RowW'($urandom);
            1: bits = '0;
            2: bits = {gkc_pkg::RowW{1'b1}} ^ (gkc_pkg::RowW'(1) << r);
            default: bits = gkc_pkg::RowW'($urandom & $urandom & $urandom) &
                            ~(gkc_pkg::RowW'(1) << r);
          endcase
          queue_load(gkc_pkg::IdxW'(r), bits);
        end
        // Now and then the loads are left without a search.
        if ($urandom_range(9) != 0) queue_search();
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
